// File: rtl/core/mecanum_wheel_speed_solver_macros.svh
// Assertion macros for the mecanum wheel speed solver.
`ifndef MECANUM_WHEEL_SPEED_SOLVER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_SOLVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/mws_pkg.sv
// Types and constants shared by the mecanum wheel speed solver.
package mws_pkg;

   localparam int VEL_W   = 16;
   localparam int GAIN_W  = 24;
   localparam int LIMIT_W = 15;
   localparam int WHEELS  = 4;
   localparam int PROD_W  = GAIN_W + VEL_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int CSR_IDX_W = 2;

   // bit i set: wheel i takes the negated term
   localparam logic [WHEELS-1:0] FWD_NEG  = 4'b0101;
   localparam logic [WHEELS-1:0] SIDE_NEG = 4'b1100;

   localparam logic signed [GAIN_W-1:0] LIN_GAIN_RST  = 24'sd65536;
   localparam logic signed [GAIN_W-1:0] TURN_GAIN_RST = 24'sd65536;
   localparam logic [LIMIT_W-1:0]       LIMIT_RST     = 15'd32767;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIN_GAIN    = 2'd0,
      CSR_TURN_GAIN   = 2'd1,
      CSR_WHEEL_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_fwd;
      logic signed [VEL_W-1:0] vel_side;
      logic signed [VEL_W-1:0] yaw_rate;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] wheel_front_a;
      logic signed [VEL_W-1:0] wheel_front_b;
      logic signed [VEL_W-1:0] wheel_rear_a;
      logic signed [VEL_W-1:0] wheel_rear_b;
   } rsp_type;

endpackage

// File: rtl/core/mws_kin.sv
// Kinematics front end: gain multiplies, wheel sums, magnitude and scaling shift.
module mws_kin #(
   parameter int FRAC_BITS = 16,
   parameter int MAG_W     = mws_pkg::ACC_W - FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  mws_pkg::req_type                   in_word,
   input  logic signed [mws_pkg::GAIN_W-1:0]  lin_gain,
   input  logic signed [mws_pkg::GAIN_W-1:0]  turn_gain,
   output logic                               out_valid,
   output logic [MAG_W-1:0]                   mag_out [mws_pkg::WHEELS],
   output logic [mws_pkg::WHEELS-1:0]         neg_out
);
   localparam int PW = mws_pkg::PROD_W;
   localparam int AW = mws_pkg::ACC_W;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] lx_ff, ly_ff, tw_ff, lx_in, ly_in, tw_in;
   logic signed [AW-1:0] acc_ff [mws_pkg::WHEELS];
   logic signed [AW-1:0] acc_in [mws_pkg::WHEELS];
   logic [MAG_W-1:0]     mag_ff [mws_pkg::WHEELS];
   logic [MAG_W-1:0]     mag_in [mws_pkg::WHEELS];
   logic [mws_pkg::WHEELS-1:0] neg_ff, neg_in;

   always_comb begin
      lx_in = PW'(lin_gain) * PW'(in_word.vel_fwd);
      ly_in = PW'(lin_gain) * PW'(in_word.vel_side);
      tw_in = PW'(turn_gain) * PW'(in_word.yaw_rate);
   end

   always_comb begin
      logic signed [AW-1:0] fx, fy;
      logic [AW-1:0]        abs_v, shf;
      for (int i = 0; i < mws_pkg::WHEELS; i++) begin
         fx = mws_pkg::FWD_NEG[i]  ? -AW'(lx_ff) : AW'(lx_ff);
         fy = mws_pkg::SIDE_NEG[i] ? -AW'(ly_ff) : AW'(ly_ff);
         acc_in[i] = AW'(tw_ff) + fx + fy;
      end
      for (int i = 0; i < mws_pkg::WHEELS; i++) begin
         neg_in[i] = acc_ff[i][AW-1];
         abs_v = neg_in[i] ? AW'(-acc_ff[i]) : AW'(acc_ff[i]);
         shf = abs_v >> FRAC_BITS;
         mag_in[i] = shf[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff  <= lx_in;
         ly_ff  <= ly_in;
         tw_ff  <= tw_in;
         acc_ff <= acc_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = v3_ff;
   assign mag_out   = mag_ff;
   assign neg_out   = neg_ff;
endmodule

// File: rtl/core/mws_div.sv
// Pipelined restoring divider lane, one quotient bit per stage, with a sideband tag.
module mws_div #(
   parameter int DEN_W = 18,
   parameter int Q_W   = 15,
   parameter int TAG_W = 17
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [DEN_W+Q_W-1:0]   num,
   input  logic [DEN_W-1:0]       den,
   input  logic [TAG_W-1:0]       tag_in,
   output logic [Q_W-1:0]         quo,
   output logic [TAG_W-1:0]       tag_out
);
   localparam int NUM_W = DEN_W + Q_W;

   logic [NUM_W-1:0] rem_ff [Q_W];
   logic [NUM_W-1:0] rem_in [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [DEN_W-1:0] den_in [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];
   logic [Q_W-1:0]   quo_in [Q_W];
   logic [TAG_W-1:0] side_ff [Q_W];
   logic [TAG_W-1:0] side_in [Q_W];

   // stage s settles quotient bit Q_W-1-s
   always_comb begin
      logic [NUM_W-1:0] rem_prev, trial;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   quo_prev;
      logic [TAG_W-1:0] side_prev;
      for (int s = 0; s < Q_W; s++) begin
         if (s == 0) begin
            rem_prev  = num;
            den_prev  = den;
            quo_prev  = '0;
            side_prev = tag_in;
         end else begin
            rem_prev  = rem_ff[s-1];
            den_prev  = den_ff[s-1];
            quo_prev  = quo_ff[s-1];
            side_prev = side_ff[s-1];
         end
         trial = {{Q_W{1'b0}}, den_prev} << (Q_W - 1 - s);
         if (rem_prev >= trial) begin
            rem_in[s] = rem_prev - trial;
            quo_in[s] = {quo_prev[Q_W-2:0], 1'b1};
         end else begin
            rem_in[s] = rem_prev;
            quo_in[s] = {quo_prev[Q_W-2:0], 1'b0};
         end
         den_in[s]  = den_prev;
         side_in[s] = side_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         quo_ff  <= quo_in;
         side_ff <= side_in;
      end
   end

   assign quo     = quo_ff[Q_W-1];
   assign tag_out = side_ff[Q_W-1];
endmodule

// File: rtl/core/mecanum_wheel_speed_solver.sv
// Top level of the mecanum wheel speed solver: config registers, peak stage, divider lanes.
//
// Turns a body velocity word (forward, sideways, yaw rate) into four mecanum
// wheel speeds. Gains are signed Q8.16 (GAIN_FRAC_BITS fraction bits); each
// wheel sum is shifted down with truncation toward zero. When the largest
// wheel magnitude exceeds wheel_limit, all four are scaled by limit/peak,
// truncated toward zero. Throughput is one word per clock while rsp_ready
// does not hold the output. The path from accept to rsp_valid has three
// kinematics stages (multiply, sum, magnitude), one peak/product stage,
// fifteen divider stages (one quotient bit each, set by the 15-bit limit),
// and the output register. The whole pipeline advances when the output
// register is empty or taken, so req_ready follows rsp_ready combinationally.
// Write the csr_ registers only when no word is in flight.
`include "mecanum_wheel_speed_solver_macros.svh"

module mecanum_wheel_speed_solver #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mws_pkg::req_type                     req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mws_pkg::rsp_type                     rsp_word,
   input  logic                                 csr_we,
   input  logic [mws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mws_pkg::GAIN_W-1:0]           csr_wdata
);
   localparam int WH    = mws_pkg::WHEELS;
   localparam int LW    = mws_pkg::LIMIT_W;
   localparam int MAG_W = mws_pkg::ACC_W - GAIN_FRAC_BITS;
   localparam int NUM_W = MAG_W + LW;
   localparam int TAG_W = LW + 2;   // {neg, scale, unscaled magnitude}

   // config registers
   logic signed [mws_pkg::GAIN_W-1:0] lin_gain_ff, turn_gain_ff;
   logic [LW-1:0]                     limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff  <= mws_pkg::LIN_GAIN_RST;
         turn_gain_ff <= mws_pkg::TURN_GAIN_RST;
         limit_ff     <= mws_pkg::LIMIT_RST;
      end else if (csr_we) begin
         case (mws_pkg::csr_index_type'(csr_index))
            mws_pkg::CSR_LIN_GAIN:    lin_gain_ff  <= csr_wdata;
            mws_pkg::CSR_TURN_GAIN:   turn_gain_ff <= csr_wdata;
            mws_pkg::CSR_WHEEL_LIMIT: limit_ff     <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // global advance: output slot free or being taken
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // kinematics front end
   logic             kin_valid;
   logic [MAG_W-1:0] kin_mag [WH];
   logic [WH-1:0]    kin_neg;

   mws_kin #(
      .FRAC_BITS (GAIN_FRAC_BITS),
      .MAG_W     (MAG_W)
   ) u_kin (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .lin_gain  (lin_gain_ff),
      .turn_gain (turn_gain_ff),
      .out_valid (kin_valid),
      .mag_out   (kin_mag),
      .neg_out   (kin_neg)
   );

   // peak stage: largest magnitude, limit compare, numerators mag*limit
   logic             s4_valid_ff;
   logic [MAG_W-1:0] s4_peak_ff, peak_in;
   logic             s4_scale_ff, scale_in;
   logic [NUM_W-1:0] s4_prod_ff [WH];
   logic [NUM_W-1:0] prod_in [WH];
   logic [TAG_W-1:0] s4_tag_ff [WH];
   logic [TAG_W-1:0] tag_in [WH];

   always_comb begin
      logic [MAG_W-1:0] pa, pb;
      pa = (kin_mag[0] > kin_mag[1]) ? kin_mag[0] : kin_mag[1];
      pb = (kin_mag[2] > kin_mag[3]) ? kin_mag[2] : kin_mag[3];
      peak_in  = (pa > pb) ? pa : pb;
      scale_in = peak_in > MAG_W'(limit_ff);
      for (int i = 0; i < WH; i++) begin
         prod_in[i] = NUM_W'(kin_mag[i]) * NUM_W'(limit_ff);
         // when no scaling applies the magnitude is at most the limit
         tag_in[i]  = {kin_neg[i], scale_in, kin_mag[i][LW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= kin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_peak_ff  <= peak_in;
         s4_scale_ff <= scale_in;
         s4_prod_ff  <= prod_in;
         s4_tag_ff   <= tag_in;
      end
   end

   // divider lanes and matching valid line
   logic [LW-1:0]    div_quo [WH];
   logic [TAG_W-1:0] div_tag [WH];
   logic [LW-1:0]    div_valid_ff;

   for (genvar i = 0; i < WH; i++) begin : g_lane
      mws_div #(
         .DEN_W (MAG_W),
         .Q_W   (LW),
         .TAG_W (TAG_W)
      ) u_div (
         .clock   (clock),
         .en      (adv),
         .num     (s4_prod_ff[i]),
         .den     (s4_peak_ff),
         .tag_in  (s4_tag_ff[i]),
         .quo     (div_quo[i]),
         .tag_out (div_tag[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
      end else if (adv) begin
         div_valid_ff <= {div_valid_ff[LW-2:0], s4_valid_ff};
      end
   end

   // output register: pick scaled or plain magnitude, restore sign
   logic                          rsp_valid_ff;
   logic signed [mws_pkg::VEL_W-1:0] wheel_in [WH];
   mws_pkg::rsp_type              rsp_word_ff;

   always_comb begin
      logic [LW-1:0] m;
      for (int i = 0; i < WH; i++) begin
         m = div_tag[i][LW] ? div_quo[i] : div_tag[i][LW-1:0];
         wheel_in[i] = div_tag[i][LW+1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid_ff[LW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_word_ff.wheel_front_a <= wheel_in[0];
         rsp_word_ff.wheel_front_b <= wheel_in[1];
         rsp_word_ff.wheel_rear_a  <= wheel_in[2];
         rsp_word_ff.wheel_rear_b  <= wheel_in[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // unscaled words never carry a magnitude above the 15-bit limit
   `MWS_ASSERT_NOW(a_bypass_fits, clock, reset, s4_valid_ff && !s4_scale_ff, (s4_peak_ff >> LW) == '0, "unscaled peak exceeds limit width")
   // scaling only when the peak is nonzero, so the divisor is never zero
   `MWS_ASSERT_NOW(a_div_nonzero, clock, reset, s4_valid_ff && s4_scale_ff, s4_peak_ff != '0, "divider fed a zero peak")
   // a held output freezes the valid line of the divider
   `MWS_ASSERT_NEXT(a_hold_freeze, clock, reset, !adv, $stable(div_valid_ff) && rsp_valid, "pipeline moved while stalled")
endmodule
